FILE: src/scrb_pkg.sv
// Shared types and command codes for the servo command register bank.
`default_nettype none

package scrb_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int NUM_ARGS  = 7;
    localparam int DRIVE_K   = 16;

    localparam logic [7:0] OP_SET_BASE   = 8'h51;
    localparam logic [7:0] OP_SET_LAST   = 8'h56;
    localparam logic [7:0] OP_QUERY_BASE = 8'h61;
    localparam logic [7:0] OP_QUERY_LAST = 8'h66;
    localparam logic [7:0] OP_SET_ALL    = 8'h71;
    localparam logic [7:0] OP_SET_PACKED = 8'h72;
    localparam logic [7:0] OP_SET_MASKED = 8'h73;

    localparam logic [7:0] CLAMP_LIMIT = 8'd100;

    // Command beat: op in the low byte, then arg1..arg7 upward.
    typedef struct packed {
        logic [NUM_ARGS-1:0][7:0] args;
        logic [7:0]               op;
    } t_cmd;

    typedef logic [NUM_SLOTS-1:0][7:0] t_duty_tbl;

    typedef struct packed {
        logic       reply_valid;
        t_duty_tbl  duty;
        logic [7:0] reply_duty;
    } t_result;

endpackage

`default_nettype wire

FILE: src/scrb_decode.sv
// Command decode: next duty table and query reply for one command beat.
`default_nettype none

module scrb_decode #(
    parameter int DIVISOR  = 8,
    parameter int CHANNELS = 6
) (
    input  var scrb_pkg::t_cmd      i_cmd,
    input  var scrb_pkg::t_duty_tbl i_duty,
    output scrb_pkg::t_result       o_res
);

    logic [7:0] w_lut [256];
    logic [7:0] w_arg1;
    logic [7:0] w_dv [scrb_pkg::NUM_ARGS];
    logic [5:0] w_mask;
    logic [2:0] w_set_idx;
    logic [2:0] w_qry_idx;

    // Position to duty: p*16/DIVISOR, low byte kept. Elaboration-time table.
    for (genvar g = 0; g < 256; g++) begin : g_lut
        assign w_lut[g] = 8'((g * scrb_pkg::DRIVE_K) / DIVISOR);
    end

    assign w_arg1 = (i_cmd.args[0] >= scrb_pkg::CLAMP_LIMIT) ?
                    scrb_pkg::CLAMP_LIMIT : i_cmd.args[0];
    assign w_mask = w_arg1[5:0];

    always_comb begin
        w_dv[0] = w_lut[w_arg1];
        for (int k = 1; k < scrb_pkg::NUM_ARGS; k++) begin
            w_dv[k] = w_lut[i_cmd.args[k]];
        end
    end

    assign w_set_idx = 3'(i_cmd.op - scrb_pkg::OP_SET_BASE);
    assign w_qry_idx = 3'(i_cmd.op - scrb_pkg::OP_QUERY_BASE);

    always_comb begin
        logic [3:0] nxt;
        nxt               = 4'd2;
        o_res.duty        = i_duty;
        o_res.reply_valid = 1'b0;
        o_res.reply_duty  = 8'd0;
        if (i_cmd.op inside {[scrb_pkg::OP_SET_BASE:scrb_pkg::OP_SET_LAST]}) begin
            if (int'(w_set_idx) < CHANNELS) begin
                o_res.duty[w_set_idx] = w_dv[0];
            end
        end else if (i_cmd.op inside
                     {[scrb_pkg::OP_QUERY_BASE:scrb_pkg::OP_QUERY_LAST]}) begin
            if (int'(w_qry_idx) < CHANNELS) begin
                o_res.reply_valid = 1'b1;
                o_res.reply_duty  = i_duty[w_qry_idx];
            end
        end else if (i_cmd.op == scrb_pkg::OP_SET_ALL) begin
            for (int i = 0; i < scrb_pkg::NUM_SLOTS; i++) begin
                if (i < CHANNELS) begin
                    o_res.duty[i] = w_dv[i];
                end
            end
        end else if (i_cmd.op == scrb_pkg::OP_SET_PACKED) begin
            // Selected channels take arg2, arg3, ... in ascending channel order.
            for (int i = 0; i < scrb_pkg::NUM_SLOTS; i++) begin
                if (i < CHANNELS && w_mask[i]) begin
                    if (!nxt[3]) begin
                        o_res.duty[i] = w_dv[3'(nxt - 4'd1)];
                    end
                    nxt = nxt + 4'd1;
                end
            end
        end else if (i_cmd.op == scrb_pkg::OP_SET_MASKED) begin
            for (int i = 0; i < scrb_pkg::NUM_SLOTS; i++) begin
                if (i < CHANNELS && w_mask[i]) begin
                    o_res.duty[i] = w_dv[1];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/servo_command_register_bank_top.sv
// Top level: servo duty register bank with stream input and output.
// Path: input register, combinational decode, result register driving the output.
// Throughput: one command beat per cycle while the output takes results; the input
// and result registers pass beats in lockstep; an output stall backs up by one beat only.
// Reset (synchronous, active low) clears all six duty values to zero and
// empties both the input register and the result register.
`default_nettype none

module servo_command_register_bank_top #(
    parameter int DIVISOR  = 8,
    parameter int CHANNELS = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // op, arg1, arg2, arg3, arg4, arg5, arg6, arg7
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // reply_duty, duty_ch1 .. duty_ch6
    output logic [0:0]  o_m_axis_tuser    // reply_valid
);

    // Input register
    logic                 r_in_valid;
    scrb_pkg::t_cmd       r_in_cmd;
    // Duty table, the only architectural state
    scrb_pkg::t_duty_tbl  r_duty;
    // Result register
    logic                 r_out_valid;
    scrb_pkg::t_result    r_out;

    scrb_pkg::t_result    w_res;
    logic                 w_in_beat;
    logic                 w_advance;

    // A command moves into the result register only when that slot is free
    // or being drained this cycle; the table commits at the same edge.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;

    scrb_decode #(
        .DIVISOR  (DIVISOR),
        .CHANNELS (CHANNELS)
    ) u_decode (
        .i_cmd  (r_in_cmd),
        .i_duty (r_duty),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_duty      <= '0;
        end else begin
            if (w_in_beat) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_duty      <= w_res.duty;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_in_cmd <= scrb_pkg::t_cmd'(i_s_axis_tdata);
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {r_out.duty, r_out.reply_duty};
    assign o_m_axis_tuser[0] = r_out.reply_valid;

endmodule

`default_nettype wire

FILE: src/scrb_checker.sv
// Port-level checks for the servo command register bank, bound to the top.
`default_nettype none

module scrb_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [55:0] o_m_axis_tdata,
    input wire [0:0]  o_m_axis_tuser
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // No reply means a zero reply byte.
    a_no_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[7:0] == 8'd0))
        else $error("reply byte nonzero without reply");

    // With the output stalled, a beat taken fills the input register, so the
    // next ready follows the output side's ready.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready && i_s_axis_tvalid && o_s_axis_tready)
        |=> (o_s_axis_tready == i_m_axis_tready))
        else $error("input ready wrong under output stall");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind servo_command_register_bank_top scrb_checker u_scrb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
